### hw/rtl/srq_pkg.sv
package srq_pkg;

	// Square root: 32 result bits, two per pipeline stage.
	localparam int SQ_ITERS  = 32;
	localparam int SQ_PER    = 2;
	localparam int SQ_STAGES = SQ_ITERS / SQ_PER;

	// Restoring divider: quotient bits resolved per pipeline stage.
	localparam int DIV_PER = 3;

	// The larger normalized magnitude lies in [2^30, 2^31).
	localparam int NORM_BITS = 31;
	localparam int LEN_BITS  = 32;

	typedef enum logic [1:0] {
		CRN_START_NEG,
		CRN_START_POS,
		CRN_END_POS,
		CRN_END_NEG
	} corner_t;

endpackage

### hw/rtl/srq_sqrt.sv
module srq_sqrt import srq_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [63:0]         radicand,
	output logic [LEN_BITS-1:0] root
);

	logic [63:0] n_s   [SQ_STAGES+1];
	logic [63:0] res_s [SQ_STAGES+1];
	logic [63:0] n_nx  [SQ_STAGES];
	logic [63:0] res_nx[SQ_STAGES];

	assign n_s[0]   = radicand;
	assign res_s[0] = '0;

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		always_comb begin
			logic [63:0] n;
			logic [63:0] r;
			logic [63:0] b;
			n = n_s[g];
			r = res_s[g];
			for (int k = 0; k < SQ_PER; k++) begin
				b = 64'd1 << (62 - 2 * (g * SQ_PER + k));
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			n_nx[g]   = n;
			res_nx[g] = r;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[g+1]   <= n_nx[g];
				res_s[g+1] <= res_nx[g];
			end
		end
	end

	assign root = res_s[SQ_STAGES][LEN_BITS-1:0];

endmodule

### hw/rtl/srq_div.sv
module srq_div import srq_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [FRAC_BITS+38:0]   num_x,
	input  logic [FRAC_BITS+38:0]   num_z,
	input  logic [LEN_BITS:0]       den,
	output logic [FRAC_BITS+4:0]    quo_x,
	output logic [FRAC_BITS+4:0]    quo_z
);

	localparam int NW = FRAC_BITS + 39;
	localparam int QW = FRAC_BITS + 5;
	localparam int DV_ST = (QW + DIV_PER - 1) / DIV_PER;

	logic [NW-1:0]     nx_s [DV_ST+1];
	logic [NW-1:0]     nz_s [DV_ST+1];
	logic [QW-1:0]     qx_s [DV_ST+1];
	logic [QW-1:0]     qz_s [DV_ST+1];
	logic [LEN_BITS:0] d_s  [DV_ST+1];

	assign nx_s[0] = num_x;
	assign nz_s[0] = num_z;
	assign qx_s[0] = '0;
	assign qz_s[0] = '0;
	assign d_s[0]  = den;

	for (genvar g = 0; g < DV_ST; g++) begin : g_stage
		logic [NW-1:0] nx_nx, nz_nx;
		logic [QW-1:0] qx_nx, qz_nx;

		always_comb begin
			logic [NW-1:0] dsh;
			int            sh;
			nx_nx = nx_s[g];
			nz_nx = nz_s[g];
			qx_nx = qx_s[g];
			qz_nx = qz_s[g];
			for (int k = 0; k < DIV_PER; k++) begin
				sh  = QW - 1 - (g * DIV_PER + k);
				dsh = NW'(d_s[g]) << ((sh < 0) ? 0 : sh);
				if (sh >= 0) begin
					if (nx_nx >= dsh) begin
						nx_nx = nx_nx - dsh;
						qx_nx = qx_nx | (QW'(1) << sh);
					end
					if (nz_nx >= dsh) begin
						nz_nx = nz_nx - dsh;
						qz_nx = qz_nx | (QW'(1) << sh);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[g+1] <= nx_nx;
				nz_s[g+1] <= nz_nx;
				qx_s[g+1] <= qx_nx;
				qz_s[g+1] <= qz_nx;
				d_s[g+1]  <= d_s[g];
			end
		end
	end

	assign quo_x = qx_s[DV_ST];
	assign quo_z = qz_s[DV_ST];

endmodule

### hw/rtl/segment_to_road_quad_top.sv
// Channel   Dir  Request                      Side band
// s_axis    in   one segment: endpoints, lanes  none
// m_axis    out  one corner: x, y, z          tuser corner/degenerate, tlast on corner 3
//
// Each segment gives four corners: the corner register hands out one corner per cycle while m_axis_tready is high.
// Pipeline: input stages, the square root (2 bits per stage), a prep stage, the divider
// (3 quotient bits per stage), a corner stage, then the corner register.
// Reset clears only valid bits and the corner counter.
// The whole pipeline freezes while its last stage holds a segment that the corner register cannot take yet;
// nothing is dropped or repeated.
module segment_to_road_quad_top import srq_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, lane_count, zero fill
	input  logic [((6*COORD_BITS+4+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// vertex_x, vertex_y, vertex_z, zero fill
	output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	// vertex_index, degenerate
	output logic [2:0] m_axis_tuser,
	output logic m_axis_tlast
);

	localparam int C      = COORD_BITS;
	localparam int MW     = C + 1;
	localparam int QW     = FRAC_BITS + 5;
	localparam int NW     = FRAC_BITS + 39;
	localparam int EW     = ((C > QW) ? C : QW) + 3;
	localparam int OUT_W  = ((3*C+7)/8)*8;
	localparam int DV_ST  = (QW + DIV_PER - 1) / DIV_PER;
	localparam int K_SUM  = 5;
	localparam int K_PREP = K_SUM + SQ_STAGES + 1;
	localparam int K_DIV  = K_PREP + DV_ST;
	localparam int T      = K_DIV + 1;

	typedef struct packed {
		logic signed [C-1:0] sx;
		logic signed [C-1:0] sy;
		logic signed [C-1:0] sz;
		logic signed [C-1:0] ex;
		logic signed [C-1:0] ey;
		logic signed [C-1:0] ez;
		logic [3:0]          lanes;
		logic                neg_px;
		logic                neg_pz;
		logic                degen;
		logic [NORM_BITS-1:0] ax;
		logic [NORM_BITS-1:0] az;
	} side_t;

	function automatic logic signed [C-1:0] sat(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] hi;
		logic signed [EW-1:0] lo;
		hi = {{(EW-C+1){1'b0}}, {(C-1){1'b1}}};
		lo = ~hi;
		if (v > hi) return hi[C-1:0];
		if (v < lo) return lo[C-1:0];
		return v[C-1:0];
	endfunction

	logic en, ser_load;
	logic [T:1] vld_s;
	side_t side_s [1:T];

	logic signed [C:0]    dx_s1, dz_s1;
	logic [MW-1:0]        axw_s2, azw_s2;
	logic [5:0]           msb_s2;
	logic [2*NORM_BITS-1:0] sqx_s4, sqz_s4;
	logic [63:0]          sum_s5;
	logic [LEN_BITS-1:0]  root;
	logic [NW-1:0]        numx_s6, numz_s6;
	logic [LEN_BITS:0]    den_s6;
	logic [QW-1:0]        quo_x, quo_z;
	logic signed [C-1:0]  cx_s7 [4];
	logic signed [C-1:0]  cz_s7 [4];

	logic signed [C-1:0]  cx_q [4];
	logic signed [C-1:0]  cz_q [4];
	logic signed [C-1:0]  sy_q, ey_q;
	logic                 dg_q, ovld_q;
	corner_t              idx_q;

	assign ser_load = !ovld_q || (m_axis_tready && idx_q == CRN_END_NEG);
	assign en = !vld_s[T] || ser_load;
	assign s_axis_tready = en;

	// Stage combinational parts.
	side_t in_side;
	logic signed [C:0] dx_in, dz_in;
	always_comb begin
		in_side        = '0;
		in_side.sx     = s_axis_tdata[C-1:0];
		in_side.sy     = s_axis_tdata[2*C-1:C];
		in_side.sz     = s_axis_tdata[3*C-1:2*C];
		in_side.ex     = s_axis_tdata[4*C-1:3*C];
		in_side.ey     = s_axis_tdata[5*C-1:4*C];
		in_side.ez     = s_axis_tdata[6*C-1:5*C];
		in_side.lanes  = s_axis_tdata[6*C+3:6*C];
		dx_in = (C+1)'(in_side.ex) - (C+1)'(in_side.sx);
		dz_in = (C+1)'(in_side.ez) - (C+1)'(in_side.sz);
	end

	logic [MW-1:0] ax_w, az_w, m_w;
	logic [5:0]    msb_w;
	always_comb begin
		ax_w = dx_s1[C] ? MW'(-dx_s1) : MW'(dx_s1);
		az_w = dz_s1[C] ? MW'(-dz_s1) : MW'(dz_s1);
		m_w  = (ax_w > az_w) ? ax_w : az_w;
		msb_w = '0;
		for (int i = 0; i < MW; i++) begin
			if (m_w[i]) msb_w = 6'(i);
		end
	end

	// The larger magnitude's top bit lands on bit 30; right shifts truncate.
	logic [63:0] axs, azs;
	always_comb begin
		axs = (64'(axw_s2) << 31) >> (7'(msb_s2) + 7'd1);
		azs = (64'(azw_s2) << 31) >> (7'(msb_s2) + 7'd1);
	end

	side_t side_s2_nx, side_s3_nx;
	always_comb begin
		side_s2_nx        = side_s[1];
		side_s2_nx.neg_px = !dz_s1[C] && (dz_s1 != '0);
		side_s2_nx.neg_pz = dx_s1[C];
		side_s2_nx.degen  = (dx_s1 == '0) && (dz_s1 == '0);
		side_s3_nx        = side_s[2];
		side_s3_nx.ax     = axs[NORM_BITS-1:0];
		side_s3_nx.az     = azs[NORM_BITS-1:0];
	end

	// A degenerate segment uses zero lanes and a length of one, giving zero offsets.
	logic [LEN_BITS-1:0] len1;
	logic [3:0]          lanes_e;
	logic [NORM_BITS+3:0] prod_x, prod_z;
	always_comb begin
		len1    = side_s[K_PREP-1].degen ? LEN_BITS'(1) : root;
		lanes_e = side_s[K_PREP-1].degen ? 4'd0 : side_s[K_PREP-1].lanes;
		prod_x  = (NORM_BITS+4)'(side_s[K_PREP-1].az) * (NORM_BITS+4)'(lanes_e);
		prod_z  = (NORM_BITS+4)'(side_s[K_PREP-1].ax) * (NORM_BITS+4)'(lanes_e);
	end

	logic signed [EW-1:0] px, pz;
	logic signed [EW-1:0] cxw [4];
	logic signed [EW-1:0] czw [4];
	always_comb begin
		px = side_s[K_DIV].neg_px ? -EW'(quo_x) : EW'(quo_x);
		pz = side_s[K_DIV].neg_pz ? -EW'(quo_z) : EW'(quo_z);
		cxw[CRN_START_NEG] = EW'(side_s[K_DIV].sx) - px;
		czw[CRN_START_NEG] = EW'(side_s[K_DIV].sz) - pz;
		cxw[CRN_START_POS] = EW'(side_s[K_DIV].sx) + px;
		czw[CRN_START_POS] = EW'(side_s[K_DIV].sz) + pz;
		cxw[CRN_END_POS]   = EW'(side_s[K_DIV].ex) + px;
		czw[CRN_END_POS]   = EW'(side_s[K_DIV].ez) + pz;
		cxw[CRN_END_NEG]   = EW'(side_s[K_DIV].ex) - px;
		czw[CRN_END_NEG]   = EW'(side_s[K_DIV].ez) - pz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[T-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= in_side;
			dx_s1     <= dx_in;
			dz_s1     <= dz_in;
			side_s[2] <= side_s2_nx;
			axw_s2    <= ax_w;
			azw_s2    <= az_w;
			msb_s2    <= msb_w;
			side_s[3] <= side_s3_nx;
			for (int k = 4; k <= T; k++) side_s[k] <= side_s[k-1];
			sqx_s4    <= (2*NORM_BITS)'(side_s[3].ax) * (2*NORM_BITS)'(side_s[3].ax);
			sqz_s4    <= (2*NORM_BITS)'(side_s[3].az) * (2*NORM_BITS)'(side_s[3].az);
			sum_s5    <= 64'(sqx_s4) + 64'(sqz_s4);
			numx_s6   <= (NW'(prod_x) << (FRAC_BITS + 2)) + NW'(len1);
			numz_s6   <= (NW'(prod_z) << (FRAC_BITS + 2)) + NW'(len1);
			den_s6    <= {len1, 1'b0};
			for (int k = 0; k < 4; k++) begin
				cx_s7[k] <= sat(cxw[k]);
				cz_s7[k] <= sat(czw[k]);
			end
		end
	end

	srq_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s5),
		.root     (root)
	);

	srq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.en    (en),
		.num_x (numx_s6),
		.num_z (numz_s6),
		.den   (den_s6),
		.quo_x (quo_x),
		.quo_z (quo_z)
	);

	// Corner register: holds one segment and hands out its corners in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			idx_q  <= CRN_START_NEG;
		end else if (ser_load) begin
			ovld_q <= vld_s[T];
			idx_q  <= CRN_START_NEG;
		end else if (m_axis_tready) begin
			idx_q  <= corner_t'(idx_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			cx_q <= cx_s7;
			cz_q <= cz_s7;
			sy_q <= side_s[T].sy;
			ey_q <= side_s[T].ey;
			dg_q <= side_s[T].degen;
		end
	end

	logic signed [C-1:0] vy;
	assign vy = (idx_q == CRN_START_NEG || idx_q == CRN_START_POS) ? sy_q : ey_q;

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = OUT_W'({cz_q[idx_q], vy, cx_q[idx_q]});
	assign m_axis_tuser  = {dg_q, idx_q};
	assign m_axis_tlast  = (idx_q == CRN_END_NEG);

	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast)
		|=> (m_axis_tvalid && idx_q == corner_t'($past(idx_q) + 2'd1)))
		else $error("corner sequence broke");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s[T] && m_axis_tvalid))
		else $error("input stalled without a blocked result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved during a stall");

	a_first_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(ser_load && vld_s[T]) |=> (m_axis_tvalid && idx_q == CRN_START_NEG))
		else $error("new segment did not start at corner zero");

endmodule

### test/tb_segment_to_road_quad_top.sv
`timescale 1ns / 100ps

module tb_segment_to_road_quad_top;
	import srq_pkg::*;

	localparam int CB = 24;
	localparam int FB = 8;
	localparam int SW = ((6*CB+4+7)/8)*8;
	localparam int MW = ((3*CB+7)/8)*8;
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		corner_t idx;
		logic last;
		logic degen;
	} corner_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [MW-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;

	corner_rec_t pending_corners[$];
	int err_count = 0;
	bit busy_src = 1'b1;
	bit busy_sink = 1'b1;

	segment_to_road_quad_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_top (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_segment_to_road_quad_top: errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic logic signed [CB-1:0] clamp_coord(input longint v);
		if (v > longint'(CMAX)) return CMAX;
		if (v < longint'(CMIN)) return CMIN;
		return v[CB-1:0];
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Computes the four quad corners for one segment and queues them.
	task automatic predict_quad(input logic signed [CB-1:0] sx, sy, sz, ex, ey, ez,
			input logic [3:0] lanes);
		longint dx, dz, px, pz, cx, cz;
		longint unsigned ax, az, m, w, len, qx, qz;
		logic degen;
		corner_rec_t c;
		dx = longint'(ex) - longint'(sx);
		dz = longint'(ez) - longint'(sz);
		px = 0;
		pz = 0;
		degen = (dx == 0 && dz == 0);
		if (!degen) begin
			ax = dx < 0 ? -dx : dx;
			az = dz < 0 ? -dz : dz;
			m = ax > az ? ax : az;
			w = longint'(lanes) << (FB + 1);
			while (m >= 64'd1 << 31) begin
				ax >>= 1; az >>= 1; m >>= 1;
			end
			while (m < 64'd1 << 30) begin
				ax <<= 1; az <<= 1; m <<= 1;
			end
			len = floor_sqrt(ax * ax + az * az);
			if (len == 0) len = 1;
			qx = (2 * az * w + len) / (2 * len);
			qz = (2 * ax * w + len) / (2 * len);
			px = dz > 0 ? -longint'(qx) : longint'(qx);
			pz = dx < 0 ? -longint'(qz) : longint'(qz);
		end
		for (int k = 0; k < 4; k++) begin
			// Corners 0 and 3 subtract the offset, 1 and 2 add it.
			cx = (k < 2 ? longint'(sx) : longint'(ex)) + ((k == 0 || k == 3) ? -px : px);
			cz = (k < 2 ? longint'(sz) : longint'(ez)) + ((k == 0 || k == 3) ? -pz : pz);
			c.x = clamp_coord(cx);
			c.z = clamp_coord(cz);
			c.y = k < 2 ? sy : ey;
			c.idx = corner_t'(k);
			c.last = (k == 3);
			c.degen = degen;
			pending_corners.push_back(c);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_segment(input logic signed [CB-1:0] sx, sy, sz, ex, ey, ez,
			input logic [3:0] lanes);
		while (busy_src && $urandom_range(99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= SW'({lanes, ez, ey, ex, sz, sy, sx});
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_quad(sx, sy, sz, ex, ey, ez, lanes);
		@(negedge clk);
	endtask

	function automatic logic signed [CB-1:0] rand_coord();
		case ($urandom_range(5))
			0: return CMAX - $urandom_range(3);
			1: return CMIN + $urandom_range(3);
			2: return $urandom_range(2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	always @(negedge clk) begin
		m_axis_tready <= busy_sink ? ($urandom_range(99) >= 33) : 1'b1;
	end

	always @(posedge clk) begin
		corner_rec_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_corners.size() == 0) begin
				report_mismatch("unexpected corner", 1, 0);
			end else begin
				want = pending_corners.pop_front();
				if ($signed(m_axis_tdata[CB-1:0]) != want.x)
					report_mismatch("vertex_x", $signed(m_axis_tdata[CB-1:0]), want.x);
				if ($signed(m_axis_tdata[2*CB-1:CB]) != want.y)
					report_mismatch("vertex_y", $signed(m_axis_tdata[2*CB-1:CB]), want.y);
				if ($signed(m_axis_tdata[3*CB-1:2*CB]) != want.z)
					report_mismatch("vertex_z", $signed(m_axis_tdata[3*CB-1:2*CB]), want.z);
				if (m_axis_tuser[1:0] != want.idx)
					report_mismatch("vertex_index", m_axis_tuser[1:0], want.idx);
				if (m_axis_tuser[2] != want.degen)
					report_mismatch("degenerate", m_axis_tuser[2], want.degen);
				if (m_axis_tlast != want.last)
					report_mismatch("last_vertex", m_axis_tlast, want.last);
			end
		end
	end

	task automatic test_directed_extremes();
		send_segment(0, 0, 0, 256, 5, 0, 1);
		send_segment(0, 0, 0, 0, 0, 256, 15);
		send_segment(100, 7, -100, 100, -7, -100, 3);
		send_segment(0, 0, 0, 0, 0, 0, 0);
		send_segment(10, 1, 10, 500, 2, -300, 0);
		send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 15);
		send_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 15);
		send_segment(CMAX, 0, 0, CMAX, 0, 1, 15);
		send_segment(CMIN, 0, CMIN, CMIN + 1, 0, CMIN, 15);
		send_segment(0, 0, 0, -1, 0, -1, 8);
		send_segment(0, 0, 0, 3, 0, -4, 4);
		send_segment(-5, -1, -5, -5, -1, -5, 15);
		send_segment(CMAX, -1, CMIN, CMIN, 0, CMAX, 1);
		send_segment(0, 0, 0, CMAX, 0, 1, 2);
	endtask

	task automatic test_random_segments(input int count);
		logic signed [CB-1:0] sx, sz;
		for (int i = 0; i < count; i++) begin
			busy_src = (i < count / 3) || (i > count / 2);
			busy_sink = busy_src;
			sx = rand_coord();
			sz = rand_coord();
			if ($urandom_range(15) == 0)
				send_segment(sx, rand_coord(), sz, sx, rand_coord(), sz, $urandom);
			else
				send_segment(sx, rand_coord(), sz, rand_coord(), rand_coord(), rand_coord(),
					$urandom);
		end
		busy_src = 1'b1;
		busy_sink = 1'b1;
	endtask

	initial begin
		int guard;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_extremes();
		test_random_segments(310);
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (pending_corners.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (pending_corners.size() != 0) report_mismatch("corners left over",
			pending_corners.size(), 0);
		if (err_count == 0) begin
			$display("tb_segment_to_road_quad_top: clean");
		end else begin
			$display("tb_segment_to_road_quad_top: errors");
		end
		$finish;
	end

endmodule
